[rtl/lfp_pkg.sv]
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and helpers for the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'h59;

	localparam logic [15:0] DIST_TOO_FAR   = 16'd65535;
	localparam logic [15:0] DIST_TOO_CLOSE = 16'd65534;
	localparam logic [15:0] DIST_UNDEFINED = 16'd65532;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_VALID     = 2'd0;
	localparam kind_t KIND_TOO_FAR   = 2'd1;
	localparam kind_t KIND_TOO_CLOSE = 2'd2;
	localparam kind_t KIND_UNDEFINED = 2'd3;

	// Frame position codes.
	typedef logic [3:0] pos_t;
	localparam pos_t POS_IDLE    = 4'd0;
	localparam pos_t POS_HDR2    = 4'd1;
	localparam pos_t POS_DIST_LO = 4'd2;
	localparam pos_t POS_DIST_HI = 4'd3;
	localparam pos_t POS_STR_LO  = 4'd4;
	localparam pos_t POS_STR_HI  = 4'd5;
	localparam pos_t POS_TEMP_LO = 4'd6;
	localparam pos_t POS_TEMP_HI = 4'd7;
	localparam pos_t POS_CSUM    = 4'd8;

	function automatic kind_t kind_of(input logic [15:0] dist_word);
		kind_t k;
		if (dist_word == DIST_TOO_FAR) begin
			k = KIND_TOO_FAR;
		end else if (dist_word == DIST_TOO_CLOSE) begin
			k = KIND_TOO_CLOSE;
		end else if (dist_word == DIST_UNDEFINED) begin
			k = KIND_UNDEFINED;
		end else begin
			k = KIND_VALID;
		end
		return k;
	endfunction

endpackage

[rtl/lfp_if.sv]
// ----------------------------------------------------------------------------
// lfp_if
// Valid/ready channels of the lidar frame parser: byte input and result output.
// ----------------------------------------------------------------------------
interface lfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance_cm;
	logic [15:0] signal_strength;
	logic [15:0] temperature_raw;
	logic [1:0]  reading_kind;

	modport source (output valid, output distance_cm, output signal_strength,
		output temperature_raw, output reading_kind, input ready);
	modport sink   (input valid, input distance_cm, input signal_strength,
		input temperature_raw, input reading_kind, output ready);
endinterface

[rtl/lidar_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// lidar_frame_parser_unit
// Byte-serial parser for nine-byte lidar frames with additive checksum.
// ----------------------------------------------------------------------------
// Output: registered; a result appears in the cycle after its checksum beat is accepted.
// Throughput: one byte per cycle unless stalled; the single output register
// stalls input only when it holds a result that is not being drained.
// Reset: arst_n clears the frame position to idle and empties the output.
module lidar_frame_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	lfp_byte_if.sink            rx,
	lfp_result_if.source        result
);
	import lfp_pkg::*;

	pos_t        pos_q;
	logic [7:0]  sum_q;
	logic [15:0] dist_q;
	logic [15:0] str_q;
	logic [15:0] temp_q;

	logic        out_valid_q;
	logic [15:0] out_dist_q;
	logic [15:0] out_str_q;
	logic [15:0] out_temp_q;
	kind_t       out_kind_q;

	logic        accept;
	logic        emit;
	logic [7:0]  b;

	assign rx.ready = !out_valid_q || result.ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign emit     = accept && (pos_q == POS_CSUM) && (sum_q == b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (accept) begin
			unique case (pos_q)
				POS_IDLE:    pos_q <= (b == HEADER_BYTE) ? POS_HDR2 : POS_IDLE;
				POS_HDR2:    pos_q <= (b == HEADER_BYTE) ? POS_DIST_LO : POS_IDLE;
				POS_DIST_LO: pos_q <= POS_DIST_HI;
				POS_DIST_HI: pos_q <= POS_STR_LO;
				POS_STR_LO:  pos_q <= POS_STR_HI;
				POS_STR_HI:  pos_q <= POS_TEMP_LO;
				POS_TEMP_LO: pos_q <= POS_TEMP_HI;
				POS_TEMP_HI: pos_q <= POS_CSUM;
				default:     pos_q <= POS_IDLE;
			endcase
		end
	end

	// Running sum and field holds; the sum is seeded by the first header beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos_q)
				POS_IDLE: begin
					sum_q <= b;
				end
				POS_DIST_LO: begin
					sum_q  <= sum_q + b;
					dist_q <= {8'd0, b};
				end
				POS_DIST_HI: begin
					sum_q        <= sum_q + b;
					dist_q[15:8] <= b;
				end
				POS_STR_LO: begin
					sum_q <= sum_q + b;
					str_q <= {8'd0, b};
				end
				POS_STR_HI: begin
					sum_q       <= sum_q + b;
					str_q[15:8] <= b;
				end
				POS_TEMP_LO: begin
					sum_q  <= sum_q + b;
					temp_q <= {8'd0, b};
				end
				POS_TEMP_HI: begin
					sum_q        <= sum_q + b;
					temp_q[15:8] <= b;
				end
				POS_HDR2: begin
					sum_q <= sum_q + b;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_dist_q <= dist_q;
			out_str_q  <= str_q;
			out_temp_q <= temp_q;
			out_kind_q <= kind_of(dist_q);
		end
	end

	assign result.valid           = out_valid_q;
	assign result.distance_cm     = out_dist_q;
	assign result.signal_strength = out_str_q;
	assign result.temperature_raw = out_temp_q;
	assign result.reading_kind    = out_kind_q;

endmodule

[tb/tb_lidar_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// tb_lidar_frame_parser_unit
// Self-checking bench for the lidar frame parser. Byte beats are fed from a
// queue, mostly as whole nine-byte frames with random content, some with a
// bad checksum or a bad second header, mixed with loose noise bytes. A local
// frame tracker predicts every reading, and each result beat is checked
// against the oldest prediction while both channels are paced at random or unthrottled.
// ----------------------------------------------------------------------------
module tb_lidar_frame_parser_unit;
	import lfp_pkg::*;

	typedef struct packed {
		logic [15:0] distance;
		logic [15:0] strength;
		logic [15:0] temp;
		kind_t       kind;
	} reading_t;

	typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_HEADER} frame_flaw_t;

	localparam int BYTES_PER_PHASE = 533;

	logic clk;
	logic arst_n;

	lfp_byte_if   byte_ch ();
	lfp_result_if reading_ch ();

	lidar_frame_parser_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (byte_ch),
		.result (reading_ch)
	);

	logic [7:0] pending_bytes [$];
	reading_t   expected_readings [$];

	// Local copy of the frame tracking state.
	pos_t        frame_pos;
	logic [7:0]  sum_acc;
	logic [15:0] dist_acc;
	logic [15:0] strength_acc;
	logic [15:0] temp_acc;

	int  src_idle_pct;
	int  sink_idle_pct;
	bit  byte_taken;
	int  bytes_accepted;
	int  frames_queued;
	int  readings_checked;
	int  error_count;

	always #5 clk = ~clk;

	task automatic track_frame_byte(input logic [7:0] b);
		reading_t r;
		case (frame_pos)
			POS_IDLE: begin
				if (b == HEADER_BYTE) begin
					sum_acc   = b;
					frame_pos = POS_HDR2;
				end
			end
			POS_HDR2: begin
				if (b == HEADER_BYTE) begin
					sum_acc   = sum_acc + b;
					frame_pos = POS_DIST_LO;
				end else begin
					frame_pos = POS_IDLE;
				end
			end
			POS_DIST_LO, POS_DIST_HI, POS_STR_LO, POS_STR_HI,
			POS_TEMP_LO, POS_TEMP_HI: begin
				// A low byte reloads its word and clears the high half.
				case (frame_pos)
					POS_DIST_LO: dist_acc = {8'h00, b};
					POS_DIST_HI: dist_acc[15:8] = b;
					POS_STR_LO:  strength_acc = {8'h00, b};
					POS_STR_HI:  strength_acc[15:8] = b;
					POS_TEMP_LO: temp_acc = {8'h00, b};
					default:     temp_acc[15:8] = b;
				endcase
				sum_acc   = sum_acc + b;
				frame_pos = frame_pos + 4'd1;
			end
			POS_CSUM: begin
				if (sum_acc == b) begin
					r.distance = dist_acc;
					r.strength = strength_acc;
					r.temp     = temp_acc;
					case (dist_acc)
						DIST_TOO_FAR:   r.kind = KIND_TOO_FAR;
						DIST_TOO_CLOSE: r.kind = KIND_TOO_CLOSE;
						DIST_UNDEFINED: r.kind = KIND_UNDEFINED;
						default:        r.kind = KIND_VALID;
					endcase
					expected_readings.push_back(r);
				end
				frame_pos = POS_IDLE;
			end
			default: frame_pos = POS_IDLE;
		endcase
	endtask

	task automatic queue_frame(input logic [15:0] distance, input logic [15:0] strength,
		input logic [15:0] temp, input frame_flaw_t flaw);
		logic [7:0] body [0:7];
		logic [7:0] csum;
		body = '{HEADER_BYTE, HEADER_BYTE, distance[7:0], distance[15:8], strength[7:0],
			strength[15:8], temp[7:0], temp[15:8]};
		if (flaw == FRAME_BAD_HEADER) begin
			do body[1] = 8'($urandom_range(255)); while (body[1] == HEADER_BYTE);
		end
		csum = 8'h00;
		foreach (body[i]) begin
			csum = csum + body[i];
			pending_bytes.push_back(body[i]);
		end
		if (flaw == FRAME_BAD_SUM) begin
			csum = csum + 8'($urandom_range(1, 255));
		end
		pending_bytes.push_back(csum);
		frames_queued++;
	endtask

	// Field values lean toward the distance codes and the word extremes.
	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		case ($urandom_range(9))
			0:       w = DIST_TOO_FAR;
			1:       w = DIST_TOO_CLOSE;
			2:       w = DIST_UNDEFINED;
			3:       w = 16'd65533;
			4:       w = 16'd0;
			default: w = 16'($urandom_range(65535));
		endcase
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || byte_ch.valid ||
			expected_readings.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Driver: both channels change on the falling edge.
	always @(negedge clk) begin
		reading_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
		end else if (!byte_ch.valid || byte_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				byte_ch.valid   <= 1'b1;
				byte_ch.rx_byte <= pending_bytes.pop_front();
			end else begin
				byte_ch.valid   <= 1'b0;
				byte_ch.rx_byte <= 8'($urandom_range(255));
			end
		end
	end

	// Monitor: checks result beats, then feeds accepted bytes to the tracker.
	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (arst_n) begin
			if (reading_ch.valid && reading_ch.ready) begin
				got = '{reading_ch.distance_cm, reading_ch.signal_strength,
					reading_ch.temperature_raw, reading_ch.reading_kind};
				if (expected_readings.size() == 0) begin
					$display({"%0t: unexpected reading: expected none, ",
						"actual dist=%0d str=%0d temp=%0d kind=%0d"},
						$time, got.distance, got.strength, got.temp, got.kind);
					error_count++;
				end else begin
					want = expected_readings.pop_front();
					if (got.distance !== want.distance || got.strength !== want.strength ||
						got.temp !== want.temp || got.kind !== want.kind) begin
						$display({"%0t: reading mismatch: ",
							"expected dist=%0d str=%0d temp=%0d kind=%0d, ",
							"actual dist=%0d str=%0d temp=%0d kind=%0d"},
							$time, want.distance, want.strength, want.temp, want.kind,
							got.distance, got.strength, got.temp, got.kind);
						error_count++;
					end
					readings_checked++;
				end
			end
			byte_taken = byte_ch.valid && byte_ch.ready;
			if (byte_taken) begin
				track_frame_byte(byte_ch.rx_byte);
				bytes_accepted++;
			end
		end
	end

	initial begin
		int          phase_bytes;
		int          roll;
		frame_flaw_t flaw;

		clk              = 1'b0;
		arst_n           = 1'b0;
		byte_ch.valid    = 1'b0;
		byte_ch.rx_byte  = 8'h00;
		reading_ch.ready = 1'b0;
		frame_pos        = POS_IDLE;
		sum_acc          = 8'h00;
		dist_acc         = 16'h0000;
		strength_acc     = 16'h0000;
		temp_acc         = 16'h0000;
		src_idle_pct     = 6;
		sink_idle_pct    = 74;
		byte_taken       = 1'b0;
		bytes_accepted   = 0;
		frames_queued    = 0;
		readings_checked = 0;
		error_count      = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Loose bytes while idle, then a header pair broken by its second byte.
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(HEADER_BYTE);
		pending_bytes.push_back(8'h58);
		queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, FRAME_GOOD);
		queue_frame(16'h0000, 16'h0000, 16'h0000, FRAME_GOOD);
		queue_frame(DIST_TOO_CLOSE, 16'h1234, 16'h00A5, FRAME_BAD_SUM);
		// Hold the sender back until every reading so far has come out.
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 6;
					sink_idle_pct = 74;
				end
				1: begin
					src_idle_pct  = 74;
					sink_idle_pct = 6;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < BYTES_PER_PHASE) begin
				roll = $urandom_range(99);
				if (roll < 20) begin
					repeat ($urandom_range(1, 3))
						pending_bytes.push_back(8'($urandom_range(255)));
				end else begin
					flaw = (roll < 30) ? FRAME_BAD_SUM :
						(roll < 38) ? FRAME_BAD_HEADER : FRAME_GOOD;
					queue_frame(pick_word(), pick_word(), pick_word(), flaw);
					phase_bytes += 9;
				end
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		$display("Covered %0d accepted bytes from %0d queued frames plus noise, %0d readings checked,",
			bytes_accepted, frames_queued, readings_checked);
		$display("under sender-heavy, receiver-heavy and unthrottled pacing; %0d errors.",
			error_count);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d readings still expected.", expected_readings.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
